// ----- hdl/tow_speed_ramp_controller_defines.svh -----
// Assertion macros for the tow speed ramp controller; tsrc_dp uses them.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef TOW_SPEED_RAMP_CONTROLLER_DEFINES_SVH
`define TOW_SPEED_RAMP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TSRC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked outside reset.
`define TSRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- hdl/tsrc_pkg.sv -----
`default_nettype none

package tsrc_pkg;

  localparam int OP_W     = 3;
  localparam int TIME_W   = 16;
  localparam int ANG_W    = 16;
  localparam int GS_W     = 16;
  localparam int SPEED_W  = 12;
  localparam int RATE_W   = 11;
  localparam int VEL_W    = 13;
  localparam int FRAC_W   = 16;
  localparam int FINE_W   = SPEED_W + FRAC_W;
  localparam int MUL_W    = 16;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int Z_W      = 15;
  localparam int FLAGS_W  = 3;
  localparam int EV_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Register limits and reset values.
  localparam logic [SPEED_W-1:0] TARGET_MIN   = 12'd26;
  localparam logic [SPEED_W-1:0] TARGET_MAX   = 12'd2304;
  localparam logic [SPEED_W-1:0] TARGET_RESET = 12'd256;
  localparam logic [RATE_W-1:0]  RATE_MIN     = 11'd26;
  localparam logic [RATE_W-1:0]  RATE_MAX     = 11'd1152;
  localparam logic [RATE_W-1:0]  ACCEL_RESET  = 11'd51;
  localparam logic [RATE_W-1:0]  DECEL_RESET  = 11'd128;

  // 0.2 m/s in 1/2^24 m/s units, and 0.5 m/s in 1/256 m/s.
  localparam logic [FINE_W-1:0]  STOP_DONE_FINE = 28'd3355443;
  localparam logic [GS_W-1:0]    MOVING_LIMIT   = 16'd128;

  // Odd polynomial sine coefficients, Q1.15 output.
  localparam logic [MUL_W-1:0]   SIN_A = 16'd25736;
  localparam logic [MUL_W-1:0]   SIN_B = 16'd10512;
  localparam logic [MUL_W-1:0]   SIN_C = 16'd1160;
  localparam logic [ANG_W-1:0]   QUARTER_TURN = 16'd16384;
  localparam logic [Z_W-1:0]     Z_QUARTER    = 15'd16384;
  localparam logic [Z_W-1:0]     SINE_PEAK    = 15'd32767;
  localparam logic [PROD_W:0]    ROUND_HALF   = 33'd16384;

  localparam logic signed [1:0] DIR_STOP = 2'sb00;
  localparam logic signed [1:0] DIR_PUSH = 2'sb11;
  localparam logic signed [1:0] DIR_TUG  = 2'sb01;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_STARTING = 2'd1,
    MODE_ACTIVE   = 2'd2,
    MODE_STOPPING = 2'd3
  } mode_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK        = 3'd0,
    OP_START_PUSH  = 3'd1,
    OP_START_TUG   = 3'd2,
    OP_STOP        = 3'd3,
    OP_TOGGLE_PUSH = 3'd4,
    OP_TOGGLE_TUG  = 3'd5,
    OP_LOADED      = 3'd6,
    OP_UNLOADED    = 3'd7
  } op_t;

  typedef enum logic [EV_W-1:0] {
    EV_NONE        = 3'd0,
    EV_NOT_LOADED  = 3'd1,
    EV_BRAKE_SET   = 3'd2,
    EV_MOVING      = 3'd3,
    EV_BRAKE_STOP  = 3'd4,
    EV_COMPLETE    = 3'd5,
    EV_IGNORED     = 3'd6
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_SPEED = 2'd0,
    CFG_ACCEL_RATE   = 2'd1,
    CFG_DECEL_RATE   = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_WAIT,
    ST_DECIDE,
    ST_RAMP_MUL,
    ST_RAMP,
    ST_ZSQ,
    ST_CMUL,
    ST_T1,
    ST_T2,
    ST_MAG,
    ST_VEL,
    ST_DONE
  } ctl_state_t;

  // Sequencer to datapath, one step per cycle unless held.
  typedef struct packed {
    logic capture;
    logic decide;
    logic ramp_mul;
    logic ramp_upd;
    logic sin_zsq;
    logic sin_cmul;
    logic sin_t1;
    logic sin_t2;
    logic sin_mag;
    logic sin_vel;
    logic publish;
  } cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic ramp_needed;
    logic resolve_needed;
    logic last_pass;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- hdl/tsrc_req_if.sv -----
`default_nettype none

interface tsrc_req_if;
  import tsrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [TIME_W-1:0] elapsed_time;
  logic [ANG_W-1:0]  heading;
  logic              brake_engaged;
  logic [GS_W-1:0]   ground_speed;

  modport source (
    output valid, operation, elapsed_time, heading, brake_engaged, ground_speed,
    input  ready
  );
  modport sink (
    input  valid, operation, elapsed_time, heading, brake_engaged, ground_speed,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/tsrc_rsp_if.sv -----
`default_nettype none

interface tsrc_rsp_if;
  import tsrc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               mode;
  logic signed [1:0]        direction;
  logic [SPEED_W-1:0]       speed;
  logic signed [VEL_W-1:0]  vel_x;
  logic signed [VEL_W-1:0]  vel_z;
  logic                     apply_force;
  logic [FLAGS_W-1:0]       condition_flags;
  logic [EV_W-1:0]          event_code;

  modport source (
    output valid, mode, direction, speed, vel_x, vel_z, apply_force,
           condition_flags, event_code,
    input  ready
  );
  modport sink (
    input  valid, mode, direction, speed, vel_x, vel_z, apply_force,
           condition_flags, event_code,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/tsrc_cfg_if.sv -----
`default_nettype none

interface tsrc_cfg_if;
  import tsrc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/tsrc_ctrl.sv -----
`default_nettype none

module tsrc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output tsrc_pkg::cmd_t  cmd,
  input  tsrc_pkg::stat_t stat
);
  import tsrc_pkg::*;

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_WAIT:     if (in_valid) state_next = ST_DECIDE;
      ST_DECIDE:   state_next = stat.ramp_needed ? ST_RAMP_MUL : ST_DONE;
      ST_RAMP_MUL: state_next = ST_RAMP;
      ST_RAMP:     state_next = stat.resolve_needed ? ST_ZSQ : ST_DONE;
      ST_ZSQ:      state_next = ST_CMUL;
      ST_CMUL:     state_next = ST_T1;
      ST_T1:       state_next = ST_T2;
      ST_T2:       state_next = ST_MAG;
      ST_MAG:      state_next = ST_VEL;
      ST_VEL:      state_next = stat.last_pass ? ST_DONE : ST_ZSQ;
      ST_DONE:     if (stat.out_free) state_next = ST_WAIT;
      default:     state_next = ST_WAIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_WAIT: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_DECIDE:   cmd.decide   = 1'b1;
      ST_RAMP_MUL: cmd.ramp_mul = 1'b1;
      ST_RAMP:     cmd.ramp_upd = 1'b1;
      ST_ZSQ:      cmd.sin_zsq  = 1'b1;
      ST_CMUL:     cmd.sin_cmul = 1'b1;
      ST_T1:       cmd.sin_t1   = 1'b1;
      ST_T2:       cmd.sin_t2   = 1'b1;
      ST_MAG:      cmd.sin_mag  = 1'b1;
      ST_VEL:      cmd.sin_vel  = 1'b1;
      ST_DONE:     cmd.publish  = stat.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/tsrc_dp.sv -----
`default_nettype none
`include "tow_speed_ramp_controller_defines.svh"

module tsrc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  tsrc_pkg::cmd_t                    cmd,
  output tsrc_pkg::stat_t                   stat,
  input  logic [tsrc_pkg::OP_W-1:0]         operation,
  input  logic [tsrc_pkg::TIME_W-1:0]       elapsed_time,
  input  logic [tsrc_pkg::ANG_W-1:0]        heading,
  input  logic                              brake_engaged,
  input  logic [tsrc_pkg::GS_W-1:0]         ground_speed,
  input  logic                              cfg_write,
  input  logic [tsrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tsrc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output tsrc_pkg::mode_t                   out_mode,
  output logic signed [1:0]                 out_dir,
  output logic [tsrc_pkg::SPEED_W-1:0]      out_speed,
  output logic signed [tsrc_pkg::VEL_W-1:0] out_vel_x,
  output logic signed [tsrc_pkg::VEL_W-1:0] out_vel_z,
  output logic                              out_force,
  output logic [tsrc_pkg::FLAGS_W-1:0]      out_flags,
  output tsrc_pkg::event_t                  out_event
);
  import tsrc_pkg::*;

  // Configuration.
  logic [SPEED_W-1:0] cruise_speed;
  logic [RATE_W-1:0]  accel_rate;
  logic [RATE_W-1:0]  decel_rate;

  // Captured item.
  op_t               op_q;
  logic [TIME_W-1:0] t_q;
  logic [ANG_W-1:0]  hdg_q;
  logic              brake_q;
  logic [GS_W-1:0]   gs_q;

  // Controller state.
  mode_t                   mode_q;
  logic signed [1:0]       dir_q;
  logic [SPEED_W-1:0]      speed_q;
  logic [FRAC_W-1:0]       frac_q;
  logic signed [VEL_W-1:0] vx_q;
  logic signed [VEL_W-1:0] vz_q;
  logic                    first_q;
  logic                    present_q;
  event_t                  ev_q;
  logic                    force_q;
  logic                    pass_q;

  // Shared multiplier and sine scratch.
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic              mul_en;
  logic [PROD_W-1:0] p_q;
  logic [Z_W-1:0]    z2_q;

  // ---------------- Command decode ----------------
  mode_t             d_mode;
  logic signed [1:0] d_dir;
  logic              d_first;
  logic              d_present;
  event_t            d_ev;
  logic              d_ramp;
  logic              d_zero_speed;
  logic              d_clear;
  logic              want_start;
  logic              want_stop;
  logic signed [1:0] start_dir;
  logic              is_idle;
  logic              moving;

  assign is_idle = (mode_q == MODE_IDLE);
  assign moving  = (gs_q > MOVING_LIMIT);

  always_comb begin
    d_mode       = mode_q;
    d_dir        = dir_q;
    d_first      = first_q;
    d_present    = present_q;
    d_ev         = EV_NONE;
    d_ramp       = 1'b0;
    d_zero_speed = 1'b0;
    d_clear      = 1'b0;
    want_start   = 1'b0;
    want_stop    = 1'b0;
    start_dir    = DIR_TUG;
    case (op_q)
      OP_TICK: begin
        if (!is_idle) begin
          // The first tick after a start counts no time and starts from rest.
          if (first_q) begin
            d_zero_speed = 1'b1;
            d_first      = 1'b0;
          end
          if (!present_q) begin
            d_clear = 1'b1;
          end else begin
            if (mode_q != MODE_STOPPING && brake_q) begin
              d_mode = MODE_STOPPING;
              d_ev   = EV_BRAKE_STOP;
            end
            d_ramp = 1'b1;
          end
        end
      end
      OP_START_PUSH: begin
        want_start = 1'b1;
        start_dir  = DIR_PUSH;
      end
      OP_START_TUG: begin
        want_start = 1'b1;
      end
      OP_STOP: begin
        want_stop = 1'b1;
      end
      OP_TOGGLE_PUSH: begin
        want_start = is_idle;
        want_stop  = !is_idle;
        start_dir  = DIR_PUSH;
      end
      OP_TOGGLE_TUG: begin
        want_start = is_idle;
        want_stop  = !is_idle;
      end
      OP_LOADED: begin
        d_clear   = 1'b1;
        d_present = 1'b1;
      end
      OP_UNLOADED: begin
        d_clear   = 1'b1;
        d_present = 1'b0;
      end
      default: begin
        d_clear = 1'b0;
      end
    endcase

    if (want_start) begin
      if (!is_idle) begin
        d_ev = EV_IGNORED;
      end else if (!present_q) begin
        d_ev = EV_NOT_LOADED;
      end else if (brake_q) begin
        d_ev = EV_BRAKE_SET;
      end else if (moving) begin
        d_ev = EV_MOVING;
      end else begin
        d_dir   = start_dir;
        d_mode  = MODE_STARTING;
        d_first = 1'b1;
      end
    end
    if (want_stop) begin
      if (is_idle) begin
        d_ev = EV_IGNORED;
      end else begin
        d_mode = MODE_STOPPING;
      end
    end
    if (d_clear) begin
      d_mode  = MODE_IDLE;
      d_dir   = DIR_STOP;
      d_first = 1'b1;
    end
  end

  // ---------------- Ramp update ----------------
  logic [FINE_W-1:0] fine;
  logic [FINE_W-1:0] tgt_fine;
  logic [FINE_W-1:0] step;
  logic [FINE_W:0]   ramp_sum;
  logic [FINE_W-1:0] r_fine;
  mode_t             r_mode;
  logic              r_done;

  assign fine     = {speed_q, frac_q};
  assign tgt_fine = {cruise_speed, {FRAC_W{1'b0}}};
  assign step     = p_q[FINE_W-1:0];
  assign ramp_sum = {1'b0, fine} + {1'b0, step};

  always_comb begin
    r_mode = mode_q;
    r_fine = fine;
    r_done = 1'b0;
    case (mode_q)
      MODE_ACTIVE: begin
        r_fine = tgt_fine;
      end
      MODE_STARTING: begin
        if (ramp_sum >= {1'b0, tgt_fine}) begin
          r_fine = tgt_fine;
          r_mode = MODE_ACTIVE;
        end else begin
          r_fine = ramp_sum[FINE_W-1:0];
        end
      end
      default: begin
        r_fine = (step >= fine) ? '0 : fine - step;
        r_done = (r_fine <= STOP_DONE_FINE);
      end
    endcase
  end

  // ---------------- Sine and resolve ----------------
  logic [ANG_W-1:0]   ang;
  logic [1:0]         quad;
  logic [Z_W-1:0]     z;
  logic [Z_W-1:0]     p_hi;
  logic [Z_W-1:0]     t1;
  logic [Z_W-1:0]     t2;
  logic [Z_W+1:0]     y_raw;
  logic [Z_W-1:0]     y;
  logic [PROD_W:0]    m_sum;
  logic [SPEED_W-1:0] m;
  logic               neg;
  logic signed [VEL_W-1:0] vel;

  assign ang   = hdg_q - (pass_q ? QUARTER_TURN : '0);
  assign quad  = ang[ANG_W-1:ANG_W-2];
  assign z     = quad[0] ? (Z_QUARTER - {1'b0, ang[ANG_W-3:0]}) : {1'b0, ang[ANG_W-3:0]};
  assign p_hi  = p_q[28:14];
  assign t1    = Z_W'(SIN_B) - p_hi;
  assign t2    = Z_W'(SIN_A) - p_hi;
  assign y_raw = p_q[29:13];
  assign y     = (y_raw > {2'b00, SINE_PEAK}) ? SINE_PEAK : y_raw[Z_W-1:0];
  assign m_sum = {1'b0, p_q} + ROUND_HALF;
  assign m     = m_sum[26:15];
  // Negative when the sine is in the lower half turn, flipped for push.
  assign neg   = quad[1] ^ dir_q[1];

  always_comb begin
    if (dir_q == DIR_STOP) begin
      vel = '0;
    end else if (neg) begin
      vel = -$signed({1'b0, m});
    end else begin
      vel = $signed({1'b0, m});
    end
  end

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    if (cmd.ramp_mul) begin
      mul_a = {{(MUL_W-RATE_W){1'b0}}, (mode_q == MODE_STARTING) ? accel_rate : decel_rate};
      mul_b = t_q;
    end else if (cmd.sin_zsq) begin
      mul_a = {1'b0, z};
      mul_b = {1'b0, z};
    end else if (cmd.sin_cmul) begin
      mul_a = SIN_C;
      mul_b = {1'b0, p_hi};
    end else if (cmd.sin_t1) begin
      mul_a = {1'b0, t1};
      mul_b = {1'b0, z2_q};
    end else if (cmd.sin_t2) begin
      mul_a = {1'b0, z};
      mul_b = {1'b0, t2};
    end else if (cmd.sin_mag) begin
      mul_a = {1'b0, y};
      mul_b = {{(MUL_W-SPEED_W){1'b0}}, speed_q};
    end else begin
      mul_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      p_q <= mul_a * mul_b;
    end
    if (cmd.sin_cmul) begin
      z2_q <= p_hi;
    end
  end

  // ---------------- Item capture ----------------
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op_t'(operation);
      t_q     <= elapsed_time;
      hdg_q   <= heading;
      brake_q <= brake_engaged;
      gs_q    <= ground_speed;
    end else if (cmd.decide && d_zero_speed) begin
      t_q <= '0;
    end
  end

  // ---------------- Controller state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q    <= MODE_IDLE;
      dir_q     <= DIR_STOP;
      speed_q   <= '0;
      frac_q    <= '0;
      vx_q      <= '0;
      vz_q      <= '0;
      first_q   <= 1'b1;
      present_q <= 1'b0;
      ev_q      <= EV_NONE;
      force_q   <= 1'b0;
      pass_q    <= 1'b0;
    end else if (cmd.decide) begin
      mode_q    <= d_mode;
      dir_q     <= d_dir;
      first_q   <= d_first;
      present_q <= d_present;
      ev_q      <= d_ev;
      force_q   <= 1'b0;
      if (d_zero_speed || d_clear) begin
        speed_q <= '0;
        frac_q  <= '0;
      end
      if (d_clear) begin
        vx_q <= '0;
        vz_q <= '0;
      end
    end else if (cmd.ramp_upd) begin
      pass_q <= 1'b0;
      if (r_done) begin
        mode_q  <= MODE_IDLE;
        dir_q   <= DIR_STOP;
        speed_q <= '0;
        frac_q  <= '0;
        vx_q    <= '0;
        vz_q    <= '0;
        first_q <= 1'b1;
        ev_q    <= EV_COMPLETE;
      end else begin
        mode_q  <= r_mode;
        speed_q <= r_fine[FINE_W-1:FRAC_W];
        frac_q  <= r_fine[FRAC_W-1:0];
      end
    end else if (cmd.sin_vel) begin
      pass_q <= 1'b1;
      if (!pass_q) begin
        vx_q <= vel;
      end else begin
        vz_q    <= vel;
        force_q <= 1'b1;
      end
    end
  end

  // ---------------- Configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cruise_speed <= TARGET_RESET;
      accel_rate   <= ACCEL_RESET;
      decel_rate   <= DECEL_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TARGET_SPEED: begin
          if (cfg_data >= TARGET_MIN && cfg_data <= TARGET_MAX) begin
            cruise_speed <= cfg_data;
          end
        end
        CFG_ACCEL_RATE: begin
          if (cfg_data[RATE_W-1:0] >= RATE_MIN && cfg_data[RATE_W-1:0] <= RATE_MAX) begin
            accel_rate <= cfg_data[RATE_W-1:0];
          end
        end
        CFG_DECEL_RATE: begin
          if (cfg_data[RATE_W-1:0] >= RATE_MIN && cfg_data[RATE_W-1:0] <= RATE_MAX) begin
            decel_rate <= cfg_data[RATE_W-1:0];
          end
        end
        default: begin
          cruise_speed <= cruise_speed;
        end
      endcase
    end
  end

  // ---------------- Result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_mode  <= mode_q;
      out_dir   <= dir_q;
      out_speed <= speed_q;
      out_vel_x <= vx_q;
      out_vel_z <= vz_q;
      out_force <= force_q;
      out_flags <= {moving, brake_q, !present_q};
      out_event <= ev_q;
    end
  end

  assign stat.ramp_needed    = d_ramp;
  assign stat.resolve_needed = !r_done && !brake_q;
  assign stat.last_pass      = pass_q;
  assign stat.out_free       = !out_valid || out_ready;

  // ---------------- Checks ----------------
  `TSRC_ASSERT_IMPL(a_idle_at_rest, mode_q == MODE_IDLE, speed_q == '0 && frac_q == '0 && dir_q == DIR_STOP && vx_q == '0 && vz_q == '0)
  `TSRC_ASSERT_IMPL(a_busy_has_dir, mode_q != MODE_IDLE, dir_q != DIR_STOP)
  `TSRC_ASSERT_IMPL(a_force_not_idle, out_valid && out_force, out_mode != MODE_IDLE)
  `TSRC_ASSERT_IMPL(a_publish_free, cmd.publish, !out_valid || out_ready)
  `TSRC_ASSERT_NEXT(a_publish_loads, cmd.publish, out_valid)

endmodule

`default_nettype wire

// ----- hdl/tow_speed_ramp_controller.sv -----
// Tow speed ramp controller.
//
// Commands and ticks arrive as words on the req channel (valid/ready); one
// result word per request leaves on the rsp channel. The cfg channel writes
// the cruise speed (index 0), accel_rate (1) and decel_rate (2); it is always
// ready, and out-of-range values are dropped. Write it only while idle.
//
// A request is taken only while the sequencer waits for work. Commands,
// ticks in idle and ticks without an aircraft go from the decide state
// straight to the final state, which publishes the result. A braked tick or
// one that ends the stop ramp also passes the ramp states; a tick that drives
// the velocities then makes two passes through the sine and resolve states,
// and the single shared 16x16 multiplier handles the ramp step and then the
// five products of each pass.
// The result register sits between the sides: a new request is accepted
// while an earlier result waits, and the next result stalls in the final
// state until the receiver takes the old one.
//
// Synchronous reset returns to idle with no aircraft loaded, zero speed,
// the register defaults, and no result pending.

`default_nettype none

module tow_speed_ramp_controller (
  input  logic  clk,
  input  logic  rst,
  tsrc_req_if.sink   req,
  tsrc_rsp_if.source rsp,
  tsrc_cfg_if.sink   cfg
);
  import tsrc_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  mode_t out_mode;
  event_t out_event;

  // The register bank never back-pressures.
  assign cfg.ready = 1'b1;

  tsrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  tsrc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .operation     (req.operation),
    .elapsed_time  (req.elapsed_time),
    .heading       (req.heading),
    .brake_engaged (req.brake_engaged),
    .ground_speed  (req.ground_speed),
    .cfg_write     (cfg.valid),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .out_ready     (rsp.ready),
    .out_valid     (rsp.valid),
    .out_mode      (out_mode),
    .out_dir       (rsp.direction),
    .out_speed     (rsp.speed),
    .out_vel_x     (rsp.vel_x),
    .out_vel_z     (rsp.vel_z),
    .out_force     (rsp.apply_force),
    .out_flags     (rsp.condition_flags),
    .out_event     (out_event)
  );

  // Enumerated codes leave the block as plain bit fields.
  assign rsp.mode       = out_mode;
  assign rsp.event_code = out_event;

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none

// Self-checking bench for the tow speed ramp controller.
//
// Command and tick words go in on the req channel and one status word comes
// back on the rsp channel for every request. A clocked driver feeds the req
// channel from a queue of pending commands. When a request word is taken, a
// behavioral copy of the controller works out the status word it should
// cause. A clocked monitor compares every status word against the oldest
// prediction.
module testbench;
  import tsrc_pkg::*;

  // Cycles to wait after the last status word has returned.
  localparam int DRAIN_CYCLES    = 24;
  // Cycles with no word moving on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int ITEMS_PER_PHASE = 140;

  typedef struct packed {
    op_t               op;
    logic [TIME_W-1:0] dt;
    logic              brake;
    logic [ANG_W-1:0]  hdg;
    logic [GS_W-1:0]   gs;
  } tow_cmd_t;

  typedef struct packed {
    mode_t                   mode;
    logic signed [1:0]       dir;
    logic [SPEED_W-1:0]      speed;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vz;
    logic                    apply;
    logic [FLAGS_W-1:0]      flags;
    event_t                  ev;
  } tow_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tsrc_req_if req ();
  tsrc_rsp_if rsp ();
  tsrc_cfg_if cfg ();

  tow_speed_ramp_controller dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Behavioral copy of the controller. The speed is kept as one fine value:
  // 12 integer bits of 1/256 m/s over 16 fraction bits, so that slow ramps
  // with short ticks still creep forward.
  // ---------------------------------------------------------------------------
  mode_t                   tow_mode;
  logic signed [1:0]       tow_dir;
  logic [31:0]             tow_fine;
  logic signed [VEL_W-1:0] tow_vx;
  logic signed [VEL_W-1:0] tow_vz;
  logic                    tow_first;
  logic                    tow_loaded;
  logic [SPEED_W-1:0]      tow_target;
  logic [RATE_W-1:0]       tow_accel;
  logic [RATE_W-1:0]       tow_decel;

  // Back to idle with everything zeroed. Aircraft presence is left alone.
  function automatic void tow_go_idle();
    tow_mode  = MODE_IDLE;
    tow_dir   = DIR_STOP;
    tow_fine  = '0;
    tow_vx    = '0;
    tow_vz    = '0;
    tow_first = 1'b1;
  endfunction

  // Q1.15 sine of an angle in 1/65536 turn. One odd polynomial covers a
  // quadrant; bit 14 mirrors the angle and bit 15 flips the sign.
  function automatic int sine_q15(input logic [ANG_W-1:0] ang);
    logic [31:0] z;
    logic [31:0] z2;
    logic [31:0] poly;
    logic [31:0] y;
    z    = ang[14] ? 32'd16384 - 32'(ang[13:0]) : 32'(ang[13:0]);
    z2   = (z * z) >> 14;
    poly = 32'(SIN_B) - ((32'(SIN_C) * z2) >> 14);
    poly = 32'(SIN_A) - ((poly * z2) >> 14);
    y    = (z * poly) >> 13;
    // The polynomial overshoots slightly at the peak.
    if (y > 32'd32767) y = 32'd32767;
    return ang[15] ? -int'(y) : int'(y);
  endfunction

  // Scales the current speed by a sine, rounded, signed by the sine and the
  // tow direction.
  function automatic logic signed [VEL_W-1:0] project_speed(input int s);
    logic [31:0] mag;
    logic [31:0] m;
    mag = (s < 0) ? 32'(-s) : 32'(s);
    m   = (mag * {20'd0, tow_fine[27:16]} + 32'd16384) >> 15;
    if (tow_dir == DIR_STOP) return '0;
    if ((s < 0) != tow_dir[1]) return -m[VEL_W-1:0];
    return m[VEL_W-1:0];
  endfunction

  function automatic logic [FLAGS_W-1:0] tow_flags(input logic brake,
                                                   input logic [GS_W-1:0] gs);
    return {gs > MOVING_LIMIT, brake, ~tow_loaded};
  endfunction

  // A start is refused for a missing aircraft first, then the brake, then
  // ground speed above half a meter per second.
  function automatic event_t tow_start(input logic signed [1:0] dir, input tow_cmd_t c);
    logic [FLAGS_W-1:0] f;
    if (tow_mode != MODE_IDLE) return EV_IGNORED;
    f = tow_flags(c.brake, c.gs);
    if (f[0]) return EV_NOT_LOADED;
    if (f[1]) return EV_BRAKE_SET;
    if (f[2]) return EV_MOVING;
    tow_dir   = dir;
    tow_mode  = MODE_STARTING;
    tow_first = 1'b1;
    return EV_NONE;
  endfunction

  function automatic event_t tow_stop();
    if (tow_mode == MODE_IDLE) return EV_IGNORED;
    tow_mode = MODE_STOPPING;
    return EV_NONE;
  endfunction

  function automatic void tow_tick(input tow_cmd_t c, inout event_t ev, inout logic apply);
    logic [31:0]      dt;
    logic [31:0]      fine;
    logic [31:0]      ceiling;
    logic [31:0]      dec;
    logic [ANG_W-1:0] cos_ang;
    if (tow_mode == MODE_IDLE) return;
    dt = 32'(c.dt);
    // The first tick after a start has no meaningful elapsed time.
    if (tow_first) begin
      dt        = '0;
      tow_fine  = '0;
      tow_first = 1'b0;
    end
    if (!tow_loaded) begin
      tow_go_idle();
      return;
    end
    if (tow_mode != MODE_STOPPING && c.brake) begin
      tow_mode = MODE_STOPPING;
      ev       = EV_BRAKE_STOP;
    end
    fine    = tow_fine;
    ceiling = {4'd0, tow_target, 16'd0};
    case (tow_mode)
      MODE_ACTIVE: begin
        fine = ceiling;
      end
      MODE_STARTING: begin
        fine = fine + 32'(tow_accel) * dt;
        if (fine >= ceiling) begin
          fine     = ceiling;
          tow_mode = MODE_ACTIVE;
        end
      end
      default: begin
        dec  = 32'(tow_decel) * dt;
        fine = (dec >= fine) ? 32'd0 : fine - dec;
        // Completion outranks a brake stop raised on the same tick.
        if (fine <= 32'(STOP_DONE_FINE)) begin
          tow_go_idle();
          ev = EV_COMPLETE;
          return;
        end
      end
    endcase
    tow_fine = {4'd0, fine[27:0]};
    // With the brake set the velocities hold their last values.
    if (c.brake) return;
    cos_ang = c.hdg - QUARTER_TURN;
    tow_vx  = project_speed(sine_q15(c.hdg));
    tow_vz  = project_speed(sine_q15(cos_ang));
    apply   = 1'b1;
  endfunction

  function automatic tow_status_t predict_tow_status(input tow_cmd_t c);
    tow_status_t s;
    event_t      ev;
    logic        apply;
    ev    = EV_NONE;
    apply = 1'b0;
    case (c.op)
      OP_TICK:        tow_tick(c, ev, apply);
      OP_START_PUSH:  ev = tow_start(DIR_PUSH, c);
      OP_START_TUG:   ev = tow_start(DIR_TUG, c);
      OP_STOP:        ev = tow_stop();
      OP_TOGGLE_PUSH: ev = (tow_mode == MODE_IDLE) ? tow_start(DIR_PUSH, c) : tow_stop();
      OP_TOGGLE_TUG:  ev = (tow_mode == MODE_IDLE) ? tow_start(DIR_TUG, c) : tow_stop();
      OP_LOADED: begin
        tow_go_idle();
        tow_loaded = 1'b1;
      end
      default: begin
        tow_go_idle();
        tow_loaded = 1'b0;
      end
    endcase
    s.mode  = tow_mode;
    s.dir   = tow_dir;
    s.speed = tow_fine[27:16];
    s.vx    = tow_vx;
    s.vz    = tow_vz;
    s.apply = apply;
    s.flags = tow_flags(c.brake, c.gs);
    s.ev    = ev;
    return s;
  endfunction

  // Register writes out of range are dropped. The rate registers only see
  // the low 11 bits of the 12-bit write data.
  function automatic void tow_write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_TARGET_SPEED: begin
        if (val >= TARGET_MIN && val <= TARGET_MAX) tow_target = val;
      end
      CFG_ACCEL_RATE: begin
        if (val[RATE_W-1:0] >= RATE_MIN && val[RATE_W-1:0] <= RATE_MAX)
          tow_accel = val[RATE_W-1:0];
      end
      CFG_DECEL_RATE: begin
        if (val[RATE_W-1:0] >= RATE_MIN && val[RATE_W-1:0] <= RATE_MAX)
          tow_decel = val[RATE_W-1:0];
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Queues shared by the driver, the monitor and the stimulus.
  // ---------------------------------------------------------------------------
  tow_cmd_t    tow_cmds[$];          // commands not yet offered on req
  tow_status_t pending_status[$];    // predictions for accepted commands
  int          words_in_flight = 0;  // commands queued whose status has not returned
  int          mismatches      = 0;
  int          phase_items     = 0;
  bit          gen_unloaded    = 1'b1;

  function automatic void queue_cmd(input op_t op, input logic [TIME_W-1:0] dt,
                                    input logic [ANG_W-1:0] hdg, input logic brake,
                                    input logic [GS_W-1:0] gs);
    tow_cmd_t c;
    c.op    = op;
    c.dt    = dt;
    c.hdg   = hdg;
    c.brake = brake;
    c.gs    = gs;
    tow_cmds.push_back(c);
    words_in_flight++;
    phase_items++;
  endfunction

  // Tick spacing leans toward whole-frame values so the ramps make progress,
  // with zero, full scale and short ticks mixed in.
  function automatic logic [TIME_W-1:0] rand_dt();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return TIME_W'($urandom_range(0, 4095));
      default: return TIME_W'($urandom_range(16384, 65535));
    endcase
  endfunction

  function automatic logic [ANG_W-1:0] rand_hdg();
    if ($urandom_range(0, 7) == 0) return ANG_W'($urandom_range(0, 7) * 8192);
    return ANG_W'($urandom);
  endfunction

  // Ground speed at or below the moving limit, so a start can go through.
  function automatic logic [GS_W-1:0] rand_slow();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return MOVING_LIMIT;
      default: return GS_W'($urandom_range(0, 128));
    endcase
  endfunction

  function automatic logic [GS_W-1:0] rand_gs();
    if ($urandom_range(0, 1) == 0) return rand_slow();
    return GS_W'($urandom);
  endfunction

  // One push or tug from start to stop: a clean start, a ramp of ticks with
  // an occasional brake, a stop by command or by brake, and ticks to ramp
  // down. Half the time the aircraft is reloaded at the end, which leaves the
  // next run starting from idle even if this one never finished slowing.
  function automatic void queue_tow_run();
    op_t start_op;
    if (gen_unloaded || $urandom_range(0, 5) == 0) begin
      queue_cmd(OP_LOADED, rand_dt(), rand_hdg(), 1'($urandom), rand_gs());
      gen_unloaded = 1'b0;
    end
    case ($urandom_range(0, 3))
      0:       start_op = OP_START_PUSH;
      1:       start_op = OP_START_TUG;
      2:       start_op = OP_TOGGLE_PUSH;
      default: start_op = OP_TOGGLE_TUG;
    endcase
    queue_cmd(start_op, rand_dt(), rand_hdg(), 1'b0, rand_slow());
    repeat ($urandom_range(2, 14))
      queue_cmd(OP_TICK, rand_dt(), rand_hdg(), $urandom_range(0, 14) == 0, rand_gs());
    case ($urandom_range(0, 2))
      0: queue_cmd(OP_STOP, rand_dt(), rand_hdg(), 1'($urandom), rand_gs());
      1: queue_cmd($urandom_range(0, 1) ? OP_TOGGLE_PUSH : OP_TOGGLE_TUG,
                   rand_dt(), rand_hdg(), 1'($urandom), rand_gs());
      default: queue_cmd(OP_TICK, rand_dt(), rand_hdg(), 1'b1, rand_gs());
    endcase
    repeat ($urandom_range(2, 16))
      queue_cmd(OP_TICK, rand_dt(), rand_hdg(), $urandom_range(0, 9) == 0, rand_gs());
    if ($urandom_range(0, 1) == 0)
      queue_cmd(OP_LOADED, rand_dt(), rand_hdg(), 1'($urandom), rand_gs());
  endfunction

  // A word with every field drawn at random.
  function automatic void queue_noise();
    op_t op;
    op = op_t'($urandom_range(0, 7));
    if (op == OP_UNLOADED) gen_unloaded = 1'b1;
    if (op == OP_LOADED) gen_unloaded = 1'b0;
    queue_cmd(op, TIME_W'($urandom), ANG_W'($urandom), 1'($urandom), GS_W'($urandom));
  endfunction

  // A start that is likely refused for the brake or for ground speed,
  // followed by a few ticks.
  function automatic void queue_refused_start();
    logic [GS_W-1:0] gs;
    gs = ($urandom_range(0, 1) == 0) ? GS_W'($urandom_range(129, 65535)) : rand_slow();
    queue_cmd($urandom_range(0, 1) ? OP_START_PUSH : OP_TOGGLE_TUG, rand_dt(), rand_hdg(),
              1'($urandom), gs);
    repeat ($urandom_range(1, 3))
      queue_cmd(OP_TICK, rand_dt(), rand_hdg(), 1'($urandom), rand_gs());
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. The sender works in bursts of random length with random gaps in
  // between. A word that was not taken stays on the bus unchanged.
  // ---------------------------------------------------------------------------
  tow_cmd_t on_bus;
  int       burst_left = 0;
  int       gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        pending_status.push_back(predict_tow_status(on_bus));
      end
      if (req.valid && !req.ready) begin
        // Holding the word until the controller takes it.
      end else if (gap_left > 0) begin
        gap_left--;
        req.valid <= 1'b0;
      end else if (tow_cmds.size() > 0) begin
        on_bus = tow_cmds.pop_front();
        req.valid         <= 1'b1;
        req.operation     <= on_bus.op;
        req.elapsed_time  <= on_bus.dt;
        req.heading       <= on_bus.hdg;
        req.brake_engaged <= on_bus.brake;
        req.ground_speed  <= on_bus.gs;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // A gap of zero lets a long run of back to back words through.
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every status word taken is checked against the oldest
  // prediction. The receiver switches now and then between always ready,
  // short stalls and long stalls.
  // ---------------------------------------------------------------------------
  function automatic void check_status();
    tow_status_t want;
    if (words_in_flight > 0) words_in_flight--;
    if (pending_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected status word: mode %0d event %0d", rsp.mode, rsp.event_code);
      return;
    end
    want = pending_status.pop_front();
    if (rsp.mode !== want.mode || rsp.direction !== want.dir ||
        rsp.speed !== want.speed || rsp.vel_x !== want.vx || rsp.vel_z !== want.vz ||
        rsp.apply_force !== want.apply || rsp.condition_flags !== want.flags ||
        rsp.event_code !== want.ev) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("status mismatch, expected: mode %0d dir %0d speed %0d vx %0d vz %0d",
                 want.mode, $signed(want.dir), want.speed, $signed(want.vx),
                 $signed(want.vz));
        $display("  apply %0d flags %0d event %0d", want.apply, want.flags, want.ev);
        $display("  got: mode %0d dir %0d speed %0d vx %0d vz %0d apply %0d flags %0d event %0d",
                 rsp.mode, $signed(rsp.direction), rsp.speed, $signed(rsp.vel_x),
                 $signed(rsp.vel_z), rsp.apply_force, rsp.condition_flags, rsp.event_code);
      end
    end
  endfunction

  int ready_style = 0;
  int style_left  = 0;
  int stall_left  = 0;

  always @(posedge clk) begin
    logic take;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) check_status();
      if (style_left == 0) begin
        ready_style = $urandom_range(0, 2);
        style_left  = $urandom_range(30, 300);
      end else begin
        style_left--;
      end
      take = 1'b1;
      if (stall_left > 0) begin
        stall_left--;
        take = 1'b0;
      end else if (ready_style == 1 && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 3);
        take       = 1'b0;
      end else if (ready_style == 2 && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(4, 30);
        take       = 1'b0;
      end
      rsp.ready <= take;
    end
  end

  // Watchdog: the run is hung if no word moves on any channel for too long.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  // Waits for every queued command to return its status, then lets the
  // controller settle before anything touches the registers.
  task automatic settle();
    while (words_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    tow_write_reg(idx, val);
  endtask

  task automatic set_ramp(input int target, input int accel, input int decel);
    write_reg(CFG_TARGET_SPEED, CFG_DATA_W'(target));
    write_reg(CFG_ACCEL_RATE, CFG_DATA_W'(accel));
    write_reg(CFG_DECEL_RATE, CFG_DATA_W'(decel));
  endtask

  // Mostly well-formed tow runs, with random words and refused starts mixed in.
  task automatic run_random_phase();
    phase_items = 0;
    while (phase_items < ITEMS_PER_PHASE) begin
      case ($urandom_range(0, 9))
        7, 8:    repeat ($urandom_range(1, 3)) queue_noise();
        9:       queue_refused_start();
        default: queue_tow_run();
      endcase
    end
    settle();
  endtask

  initial begin
    req.valid         = 1'b0;
    req.operation     = OP_TICK;
    req.elapsed_time  = '0;
    req.heading       = '0;
    req.brake_engaged = 1'b0;
    req.ground_speed  = '0;
    rsp.ready         = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = CFG_TARGET_SPEED;
    cfg.data          = '0;
    tow_target        = TARGET_RESET;
    tow_accel         = ACCEL_RESET;
    tow_decel         = DECEL_RESET;
    tow_loaded        = 1'b0;
    tow_go_idle();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the registers at their reset values.
    // Idle tick, a start with no aircraft, and a stop while idle.
    queue_cmd(OP_TICK, 16'hFFFF, 16'h0000, 1'b0, 16'd0);
    queue_cmd(OP_START_PUSH, 16'd0, 16'd0, 1'b0, 16'd0);
    queue_cmd(OP_STOP, 16'd0, 16'd0, 1'b0, 16'd0);
    queue_cmd(OP_LOADED, 16'd0, 16'd0, 1'b0, 16'd0);
    // Brake outranks ground speed; then ground speed just over and at the limit.
    queue_cmd(OP_START_TUG, 16'd0, 16'd0, 1'b1, 16'hFFFF);
    queue_cmd(OP_START_PUSH, 16'd0, 16'd0, 1'b0, 16'd129);
    queue_cmd(OP_START_PUSH, 16'd0, 16'd0, 1'b0, 16'd128);
    // A start while already moving is ignored.
    queue_cmd(OP_START_TUG, 16'd0, 16'd0, 1'b0, 16'd0);
    // First tick zeroes the speed; then a ramp through every quadrant,
    // the sine peak and a tick of zero length, until the target is reached.
    queue_cmd(OP_TICK, 16'hFFFF, 16'h0000, 1'b0, 16'd0);
    queue_cmd(OP_TICK, 16'hFFFF, 16'h4000, 1'b0, 16'd0);
    queue_cmd(OP_TICK, 16'hFFFF, 16'h8000, 1'b0, 16'hFFFF);
    queue_cmd(OP_TICK, 16'hFFFF, 16'hC000, 1'b0, 16'd0);
    queue_cmd(OP_TICK, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0);
    queue_cmd(OP_TICK, 16'h0000, 16'h2000, 1'b0, 16'd0);
    queue_cmd(OP_TICK, 16'hFFFF, 16'h6000, 1'b0, 16'd0);
    queue_cmd(OP_TICK, 16'hFFFF, 16'hA000, 1'b0, 16'd0);
    queue_cmd(OP_TICK, 16'hFFFF, 16'hE000, 1'b0, 16'd0);
    // Brake while active stops with no force; the next tick completes.
    queue_cmd(OP_TICK, 16'hFFFF, 16'h0000, 1'b1, 16'd0);
    queue_cmd(OP_TICK, 16'hFFFF, 16'h0000, 1'b1, 16'd0);
    // Toggle from idle starts. Brake on the first tick both brakes and
    // completes in one go, since the speed is still zero.
    queue_cmd(OP_TOGGLE_TUG, 16'd0, 16'd0, 1'b0, 16'd0);
    queue_cmd(OP_TICK, 16'd1000, 16'd12345, 1'b1, 16'd0);
    // Toggle while moving stops; unloading resets mid-run.
    queue_cmd(OP_TOGGLE_PUSH, 16'd0, 16'd0, 1'b0, 16'd0);
    queue_cmd(OP_TICK, 16'hFFFF, 16'h1234, 1'b0, 16'd0);
    queue_cmd(OP_TOGGLE_PUSH, 16'd0, 16'd0, 1'b0, 16'd0);
    queue_cmd(OP_UNLOADED, 16'd0, 16'd0, 1'b0, 16'd0);
    queue_cmd(OP_TICK, 16'hFFFF, 16'h0000, 1'b0, 16'd0);
    queue_cmd(OP_LOADED, 16'd0, 16'd0, 1'b0, 16'd0);
    gen_unloaded = 1'b0;
    settle();

    // Everything at its upper limit.
    set_ramp(2304, 1152, 1152);
    run_random_phase();

    // Everything at its lower limit: the target sits below the stop
    // threshold, so any stopping tick completes.
    set_ramp(26, 26, 26);
    run_random_phase();

    // Writes that must be dropped, then ones that land after the rate
    // registers lose the top data bit.
    write_reg(CFG_TARGET_SPEED, 12'd4095);
    write_reg(CFG_TARGET_SPEED, 12'd0);
    write_reg(CFG_TARGET_SPEED, 12'd25);
    write_reg(CFG_TARGET_SPEED, 12'd2305);
    write_reg(CFG_ACCEL_RATE, 12'd2047);
    write_reg(CFG_ACCEL_RATE, 12'd25);
    write_reg(CFG_ACCEL_RATE, 12'd1153);
    write_reg(CFG_DECEL_RATE, 12'd0);
    write_reg(CFG_DECEL_RATE, 12'd1153);
    run_random_phase();
    write_reg(CFG_ACCEL_RATE, 12'd2148);
    write_reg(CFG_DECEL_RATE, 12'd3000);
    write_reg(CFG_TARGET_SPEED, CFG_DATA_W'($urandom_range(26, 2304)));
    run_random_phase();

    // A random setting across the whole legal range.
    set_ramp($urandom_range(26, 2304), $urandom_range(26, 1152), $urandom_range(26, 1152));
    run_random_phase();

    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- tow_speed_ramp_controller.f -----
+incdir+hdl
hdl/tsrc_pkg.sv
hdl/tsrc_req_if.sv
hdl/tsrc_rsp_if.sv
hdl/tsrc_cfg_if.sv
hdl/tsrc_ctrl.sv
hdl/tsrc_dp.sv
hdl/tow_speed_ramp_controller.sv
dv/testbench.sv
